// ----- src/nearest_neighbour_tour_assert.svh -----
// assertion macros shared by the nearest neighbour tour block
`ifndef NEAREST_NEIGHBOUR_TOUR_ASSERT_SVH
`define NEAREST_NEIGHBOUR_TOUR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define NNT_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nnt assertion failed");

// consequent checked in the cycle after the antecedent
`define NNT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nnt assertion failed");

`endif

// ----- src/nnt_pkg.sv -----
// shared widths, constants and control types of the nearest neighbour tour block
package nnt_pkg;

    localparam int TOWN_W    = 6;
    localparam int DIST_IN_W = 24;
    localparam int LEN_W     = 30;
    localparam int CNT_W     = 7;

    localparam logic [CNT_W-1:0] TOWN_COUNT_RESET = 7'd64;
    localparam logic [CNT_W-1:0] MIN_TOWNS        = 7'd2;
    localparam logic [LEN_W-1:0] LENGTH_MAX       = {LEN_W{1'b1}};

    // sequencer controls for the shared compare and accumulate unit
    typedef struct packed {
        logic scan_start;
        logic cmp_en;
        logic acc_clear;
        logic acc_en;
        logic acc_close;
    } unit_ctl_t;

endpackage

// ----- src/nnt_ram.sv -----
// generic single write port ram with registered read
module nnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/nnt_unit.sv -----
// shared nearest town compare and saturating tour length accumulator
module nnt_unit #(
    parameter int DIST_W = 24,
    parameter int IW     = 6
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  nnt_pkg::unit_ctl_t     ctl,
    input  logic [DIST_W-1:0]      rd_data,
    input  logic [IW-1:0]          cand_town,
    output logic [IW-1:0]          nearest_town,
    output logic [nnt_pkg::LEN_W-1:0] length
);

    logic                      found_reg;
    logic                      found_next;
    logic [DIST_W-1:0]         nearest_dist_reg;
    logic [IW-1:0]             nearest_town_reg;
    logic [nnt_pkg::LEN_W-1:0] length_reg;
    logic [nnt_pkg::LEN_W-1:0] length_next;
    logic                      take;
    logic [DIST_W-1:0]         addend;
    logic [nnt_pkg::LEN_W:0]   sum;

    always_comb begin
        // strict less-than keeps the lowest index on a tie
        take   = ctl.cmp_en && (!found_reg || (rd_data < nearest_dist_reg));
        addend = ctl.acc_close ? rd_data : nearest_dist_reg;
        sum    = {1'b0, length_reg} + (nnt_pkg::LEN_W + 1)'(addend);

        found_next = found_reg;
        if (ctl.scan_start) begin
            found_next = 1'b0;
        end else if (take) begin
            found_next = 1'b1;
        end

        length_next = length_reg;
        if (ctl.acc_clear) begin
            length_next = '0;
        end else if (ctl.acc_en) begin
            length_next = sum[nnt_pkg::LEN_W] ? nnt_pkg::LENGTH_MAX
                                              : sum[nnt_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            nearest_dist_reg <= rd_data;
            nearest_town_reg <= cand_town;
        end
        length_reg <= length_next;
    end

    assign nearest_town = nearest_town_reg;
    assign length       = length_reg;

endmodule

// ----- src/nearest_neighbour_tour.sv -----
// top level of the nearest neighbour tour block: sequencer, stores and output register
//
// Usage: matrix entries arrive on the s_ channel, one request per entry,
// addressed by s_from_town and s_to_town. Entries load at one per cycle
// while idle. The request with s_final_entry set is stored and then starts a
// greedy tour from town 0 over cfg_data towns (clamped to 2..64, 64 after
// reset; it is to be written through the cfg_ channel while idle, which the
// block itself does not enforce). Each step scans the unvisited towns through
// one registered distance memory read per cycle and one shared compare unit,
// then commits the nearest town.
// The tour then leaves on the m_ channel, one request per town, each read from
// the tour store into the output register and held there until m_ready takes
// it; the last one carries the closed length. s_ready stays low from the final
// entry until the last town is taken; a stall on m_ready simply holds the
// output register. Reset (synchronous, aresetn low) returns to idle with the
// town count at 64; matrix contents are kept and never cleared.
//
module nearest_neighbour_tour #(
    parameter int MAX_TOWNS = 64,
    parameter int DIST_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [nnt_pkg::CNT_W-1:0]    cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [nnt_pkg::TOWN_W-1:0]   s_from_town,
    input  logic [nnt_pkg::TOWN_W-1:0]   s_to_town,
    input  logic [nnt_pkg::DIST_IN_W-1:0] s_distance,
    input  logic                         s_final_entry,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [nnt_pkg::TOWN_W-1:0]   m_tour_position,
    output logic [nnt_pkg::TOWN_W-1:0]   m_tour_town,
    output logic [nnt_pkg::LEN_W-1:0]    m_tour_length,
    output logic                         m_last_of_tour
);

    localparam int TOUR_LIMIT = (MAX_TOWNS < 64) ? MAX_TOWNS : 64;
    localparam int IW         = $clog2(TOUR_LIMIT);
    localparam int AW         = $clog2(MAX_TOWNS * MAX_TOWNS);
    localparam int DIST_W     = (DIST_BITS < nnt_pkg::DIST_IN_W) ? DIST_BITS
                                                                 : nnt_pkg::DIST_IN_W;
    localparam logic [AW-1:0] ROW = AW'(MAX_TOWNS);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SCAN      = 4'd1;
    localparam logic [3:0] ST_DRAIN     = 4'd2;
    localparam logic [3:0] ST_STEP      = 4'd3;
    localparam logic [3:0] ST_CLOSE     = 4'd4;
    localparam logic [3:0] ST_CLOSE_ADD = 4'd5;
    localparam logic [3:0] ST_EMIT_RD   = 4'd6;
    localparam logic [3:0] ST_EMIT_LD   = 4'd7;
    localparam logic [3:0] ST_EMIT_WAIT = 4'd8;

    logic [3:0]                state_reg, state_next;
    logic [nnt_pkg::CNT_W-1:0] town_count_reg;
    logic [IW-1:0]             last_idx_reg, last_idx_next;
    logic [IW-1:0]             cur_reg, cur_next;
    logic [IW-1:0]             step_reg, step_next;
    logic [IW-1:0]             j_reg, j_next;
    logic [IW-1:0]             pos_reg, pos_next;
    logic [TOUR_LIMIT-1:0]     visited_reg, visited_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic [IW-1:0]             rd_j_reg, rd_j_next;
    logic                      m_valid_reg, m_valid_next;
    logic [nnt_pkg::TOWN_W-1:0] m_pos_reg, m_town_reg;
    logic [nnt_pkg::LEN_W-1:0] m_len_reg;
    logic                      m_last_reg;
    logic                      out_load;

    logic                      s_accept;
    logic                      in_range;
    logic [IW-1:0]             clamp_last;
    logic [nnt_pkg::CNT_W-1:0] tc_m1;

    logic                      dist_wr_en;
    logic [AW-1:0]             dist_wr_addr;
    logic [AW-1:0]             dist_rd_addr;
    logic [IW-1:0]             dist_col;
    logic [DIST_W-1:0]         dist_rd_data;

    logic                      tour_wr_en;
    logic [IW-1:0]             tour_wr_addr;
    logic [IW-1:0]             tour_wr_data;
    logic                      tour_rd_en;
    logic [IW-1:0]             tour_rd_data;

    nnt_pkg::unit_ctl_t        ctl;
    logic [IW-1:0]             nearest_town;
    logic [nnt_pkg::LEN_W-1:0] length;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign in_range  = (32'(s_from_town) < MAX_TOWNS) && (32'(s_to_town) < MAX_TOWNS);

    // town count clamped to 2..limit, kept as the index of the last town
    always_comb begin
        tc_m1 = town_count_reg - nnt_pkg::CNT_W'(1);
        if (town_count_reg < nnt_pkg::MIN_TOWNS) begin
            clamp_last = IW'(1);
        end else if (32'(town_count_reg) > TOUR_LIMIT) begin
            clamp_last = IW'(TOUR_LIMIT - 1);
        end else begin
            clamp_last = tc_m1[IW-1:0];
        end
    end

    assign dist_wr_en   = s_accept && in_range;
    assign dist_wr_addr = AW'(s_from_town) * ROW + AW'(s_to_town);
    assign dist_col     = (state_reg == ST_CLOSE) ? '0 : j_reg;
    assign dist_rd_addr = AW'(cur_reg) * ROW + AW'(dist_col);

    nnt_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_TOWNS * MAX_TOWNS)
    ) u_dist_ram (
        .aclk    (aclk),
        .wr_en   (dist_wr_en),
        .wr_addr (dist_wr_addr),
        .wr_data (s_distance[DIST_W-1:0]),
        .rd_en   (1'b1),
        .rd_addr (dist_rd_addr),
        .rd_data (dist_rd_data)
    );

    nnt_ram #(
        .WIDTH (IW),
        .DEPTH (TOUR_LIMIT)
    ) u_tour_ram (
        .aclk    (aclk),
        .wr_en   (tour_wr_en),
        .wr_addr (tour_wr_addr),
        .wr_data (tour_wr_data),
        .rd_en   (tour_rd_en),
        .rd_addr (pos_reg),
        .rd_data (tour_rd_data)
    );

    nnt_unit #(
        .DIST_W (DIST_W),
        .IW     (IW)
    ) u_unit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .rd_data      (dist_rd_data),
        .cand_town    (rd_j_reg),
        .nearest_town (nearest_town),
        .length       (length)
    );

    always_comb begin
        state_next    = state_reg;
        last_idx_next = last_idx_reg;
        cur_next      = cur_reg;
        step_next     = step_reg;
        j_next        = j_reg;
        pos_next      = pos_reg;
        visited_next  = visited_reg;
        rd_vld_next   = 1'b0;
        rd_j_next     = rd_j_reg;
        m_valid_next  = m_valid_reg;
        out_load      = 1'b0;
        tour_wr_en    = 1'b0;
        tour_wr_addr  = step_reg;
        tour_wr_data  = nearest_town;
        tour_rd_en    = 1'b0;
        ctl           = '0;
        ctl.cmp_en    = rd_vld_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_final_entry) begin
                    visited_next    = '0;
                    visited_next[0] = 1'b1;
                    cur_next        = '0;
                    step_next       = IW'(1);
                    j_next          = IW'(1);
                    last_idx_next   = clamp_last;
                    ctl.scan_start  = 1'b1;
                    ctl.acc_clear   = 1'b1;
                    tour_wr_en      = 1'b1;
                    tour_wr_addr    = '0;
                    tour_wr_data    = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read issued now, compared next cycle
                rd_vld_next = !visited_reg[j_reg];
                rd_j_next   = j_reg;
                j_next      = j_reg + IW'(1);
                if (j_reg == last_idx_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_STEP;
            end
            ST_STEP: begin
                ctl.acc_en                 = 1'b1;
                visited_next[nearest_town] = 1'b1;
                tour_wr_en                 = 1'b1;
                cur_next                   = nearest_town;
                if (step_reg == last_idx_reg) begin
                    state_next = ST_CLOSE;
                end else begin
                    step_next      = step_reg + IW'(1);
                    j_next         = IW'(1);
                    ctl.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_CLOSE: begin
                state_next = ST_CLOSE_ADD;
            end
            ST_CLOSE_ADD: begin
                // edge back to town 0 closes the tour
                ctl.acc_en    = 1'b1;
                ctl.acc_close = 1'b1;
                pos_next      = '0;
                state_next    = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                tour_rd_en = 1'b1;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                out_load     = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (pos_reg == last_idx_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next   = pos_reg + IW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            town_count_reg <= nnt_pkg::TOWN_COUNT_RESET;
            visited_reg    <= '0;
            rd_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            last_idx_reg   <= IW'(1);
            cur_reg        <= '0;
            step_reg       <= '0;
            j_reg          <= '0;
            pos_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            visited_reg  <= visited_next;
            rd_vld_reg   <= rd_vld_next;
            m_valid_reg  <= m_valid_next;
            last_idx_reg <= last_idx_next;
            cur_reg      <= cur_next;
            step_reg     <= step_next;
            j_reg        <= j_next;
            pos_reg      <= pos_next;
            if (cfg_valid && cfg_ready) begin
                town_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_j_reg <= rd_j_next;
        if (out_load) begin
            m_pos_reg  <= nnt_pkg::TOWN_W'(pos_reg);
            m_town_reg <= nnt_pkg::TOWN_W'(tour_rd_data);
            m_last_reg <= (pos_reg == last_idx_reg);
            m_len_reg  <= (pos_reg == last_idx_reg) ? length : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_tour_position = m_pos_reg;
    assign m_tour_town     = m_town_reg;
    assign m_tour_length   = m_len_reg;
    assign m_last_of_tour  = m_last_reg;

`include "nearest_neighbour_tour_assert.svh"

    // no new entries while a tour is being sent
    `NNT_ASSERT_NOW(a_busy_while_emitting, aclk, aresetn, m_valid, !s_ready)
    // the last town of the tour sits at the last position
    `NNT_ASSERT_NOW(a_last_position, aclk, aresetn, m_valid && m_last_of_tour,
                    m_tour_position == nnt_pkg::TOWN_W'(last_idx_reg))
    // length is only carried on the last town
    `NNT_ASSERT_NOW(a_length_on_last, aclk, aresetn, m_valid && !m_last_of_tour,
                    m_tour_length == '0)
    // once the last town is taken the block is ready for a new matrix
    `NNT_ASSERT_NEXT(a_ready_after_tour, aclk, aresetn,
                     m_valid && m_ready && m_last_of_tour, s_ready && !m_valid)

endmodule

// ----- bench/nearest_neighbour_tour_tb.sv -----
// self-checking bench for the nearest neighbour tour block: matrix loads, greedy tours, ties
`timescale 1ns / 100ps

module nearest_neighbour_tour_tb;

    localparam int TOWN_W    = nnt_pkg::TOWN_W;
    localparam int DIST_IN_W = nnt_pkg::DIST_IN_W;
    localparam int LEN_W     = nnt_pkg::LEN_W;
    localparam int CNT_W     = nnt_pkg::CNT_W;
    localparam logic [CNT_W-1:0] TOWN_COUNT_RESET = nnt_pkg::TOWN_COUNT_RESET;
    localparam logic [CNT_W-1:0] MIN_TOWNS        = nnt_pkg::MIN_TOWNS;
    localparam logic [LEN_W-1:0] LENGTH_MAX       = nnt_pkg::LENGTH_MAX;

    localparam int TOWN_LIMIT     = 64;
    localparam int FULL_TOWNS     = 12;
    localparam int RANDOM_ENTRIES = 160;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 32;
    localparam int CYCLE_LIMIT    = 2000000;
    localparam logic [DIST_IN_W-1:0] FAR_AWAY = {DIST_IN_W{1'b1}};

    typedef struct packed {
        logic [TOWN_W-1:0] position;
        logic [TOWN_W-1:0] town;
        logic [LEN_W-1:0]  length;
        logic              closing;
    } tour_stop_t;

    // keeps its own copy of the matrix and town count, plans each tour greedily
    class tour_tracker;
        logic [DIST_IN_W-1:0] dist_matrix [TOWN_LIMIT*TOWN_LIMIT];
        logic [CNT_W-1:0]     town_count;
        tour_stop_t           planned_stops[$];
        int unsigned          errors;
        int unsigned          tours_planned;
        int unsigned          stops_checked;

        function new();
            town_count = TOWN_COUNT_RESET;
            errors = 0;
            tours_planned = 0;
            stops_checked = 0;
        endfunction

        function void set_town_count(logic [CNT_W-1:0] value);
            town_count = value;
        endfunction

        function int unsigned tour_size();
            if (town_count < MIN_TOWNS)
                return 32'(MIN_TOWNS);
            if (town_count > TOWN_LIMIT)
                return TOWN_LIMIT;
            return 32'(town_count);
        endfunction

        function logic [LEN_W:0] capped_sum(logic [LEN_W:0] sum, logic [DIST_IN_W-1:0] d);
            logic [LEN_W:0] total;
            total = sum + (LEN_W + 1)'(d);
            if (total > (LEN_W + 1)'(LENGTH_MAX))
                total = (LEN_W + 1)'(LENGTH_MAX);
            return total;
        endfunction

        function void plan_greedy_tour();
            int unsigned          n;
            int unsigned          here;
            int unsigned          best_town;
            logic [DIST_IN_W-1:0] best_dist;
            logic [DIST_IN_W-1:0] d;
            logic [LEN_W:0]       total;
            bit                   found;
            bit                   seen [TOWN_LIMIT];
            int unsigned          route [TOWN_LIMIT];
            tour_stop_t           stop;
            n = tour_size();
            foreach (seen[k])
                seen[k] = 1'b0;
            seen[0] = 1'b1;
            route[0] = 0;
            here = 0;
            total = '0;
            for (int unsigned step = 1; step < n; step++) begin
                found = 1'b0;
                best_dist = '0;
                best_town = 0;
                // lowest index wins on a tie since only a strictly shorter edge replaces it
                for (int unsigned j = 1; j < n; j++) begin
                    if (!seen[j]) begin
                        d = dist_matrix[here*TOWN_LIMIT + j];
                        if (!found || d < best_dist) begin
                            found = 1'b1;
                            best_dist = d;
                            best_town = j;
                        end
                    end
                end
                total = capped_sum(total, best_dist);
                seen[best_town] = 1'b1;
                route[step] = best_town;
                here = best_town;
            end
            total = capped_sum(total, dist_matrix[here*TOWN_LIMIT]);
            for (int unsigned p = 0; p < n; p++) begin
                stop.position = TOWN_W'(p);
                stop.town = TOWN_W'(route[p]);
                stop.closing = (p == n - 1);
                stop.length = stop.closing ? total[LEN_W-1:0] : '0;
                planned_stops = {planned_stops, stop};
            end
            tours_planned++;
        endfunction

        function void note_entry(logic [TOWN_W-1:0] from_t, logic [TOWN_W-1:0] to_t,
                                 logic [DIST_IN_W-1:0] span, bit closing);
            dist_matrix[from_t*TOWN_LIMIT + to_t] = span;
            if (closing)
                plan_greedy_tour();
        endfunction

        function void check_stop(tour_stop_t got);
            tour_stop_t want;
            if (planned_stops.size() == 0) begin
                $display("%0t: unexpected tour stop: expected none, got position %0d town %0d",
                         $time, got.position, got.town);
                errors++;
                return;
            end
            want = planned_stops.pop_front();
            stops_checked++;
            if (got.position !== want.position) begin
                $display("%0t: tour_position mismatch: expected %0d, got %0d",
                         $time, want.position, got.position);
                errors++;
            end
            if (got.town !== want.town) begin
                $display("%0t: tour_town mismatch at position %0d: expected %0d, got %0d",
                         $time, want.position, want.town, got.town);
                errors++;
            end
            if (got.length !== want.length) begin
                $display("%0t: tour_length mismatch at position %0d: expected %0h, got %0h",
                         $time, want.position, want.length, got.length);
                errors++;
            end
            if (got.closing !== want.closing) begin
                $display("%0t: last_of_tour mismatch at position %0d: expected %0b, got %0b",
                         $time, want.position, want.closing, got.closing);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [TOWN_W-1:0]    s_from_town;
    logic [TOWN_W-1:0]    s_to_town;
    logic [DIST_IN_W-1:0] s_distance;
    logic                 s_final_entry;
    logic                 m_valid;
    logic                 m_ready;
    logic [TOWN_W-1:0]    m_tour_position;
    logic [TOWN_W-1:0]    m_tour_town;
    logic [LEN_W-1:0]     m_tour_length;
    logic                 m_last_of_tour;

    tour_tracker tracker;
    bit          steady = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned entries_sent = 0;

    nearest_neighbour_tour uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_from_town     (s_from_town),
        .s_to_town       (s_to_town),
        .s_distance      (s_distance),
        .s_final_entry   (s_final_entry),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tour_position (m_tour_position),
        .m_tour_town     (m_tour_town),
        .m_tour_length   (m_tour_length),
        .m_last_of_tour  (m_last_of_tour)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver side stalls at random outside the steady stretch
    initial m_ready = 1'b0;
    always @(negedge aclk) begin
        if (steady)
            m_ready = 1'b1;
        else
            m_ready = ($urandom_range(0, 99) >= 31);
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            tracker.check_stop('{m_tour_position, m_tour_town, m_tour_length, m_last_of_tour});
    end

    function automatic logic [DIST_IN_W-1:0] pick_distance();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return FAR_AWAY;
            2: return DIST_IN_W'($urandom_range(0, 7));
            default: return DIST_IN_W'($urandom);
        endcase
    endfunction

    // counts stay within the fully loaded corner of the matrix
    function automatic logic [CNT_W-1:0] pick_town_count();
        case ($urandom_range(0, 9))
            0: return CNT_W'($urandom_range(0, FULL_TOWNS));
            1: return CNT_W'($urandom_range(0, 1));
            default: return CNT_W'($urandom_range(2, FULL_TOWNS));
        endcase
    endfunction

    task automatic send_entry(input logic [TOWN_W-1:0] from_t, input logic [TOWN_W-1:0] to_t,
                              input logic [DIST_IN_W-1:0] span, input bit closing);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 31) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_from_town = from_t;
        s_to_town = to_t;
        s_distance = span;
        s_final_entry = closing;
        s_valid = 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tracker.note_entry(from_t, to_t, span, closing);
        entries_sent++;
    endtask

    // hold the sender off until the block has handed over every planned stop
    task automatic await_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (tracker.planned_stops.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_town_count(input logic [CNT_W-1:0] value);
        await_idle();
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        tracker.set_town_count(value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        int unsigned n;
        int unsigned count;
        int unsigned tour_no;
        int unsigned random_entries;
        tracker = new();
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_from_town = '0;
        s_to_town = '0;
        s_distance = '0;
        s_final_entry = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // count of zero clamps to two towns; zero and full-scale edges
        write_town_count(7'd0);
        send_entry(6'd0, 6'd1, '0, 1'b0);
        send_entry(6'd1, 6'd0, FAR_AWAY, 1'b1);
        // a diagonal entry as the final request is stored but never read
        send_entry(6'd1, 6'd1, 24'h123456, 1'b1);

        // three towns with a tie out of town 0
        write_town_count(7'd3);
        send_entry(6'd0, 6'd1, 24'd5, 1'b0);
        send_entry(6'd0, 6'd2, 24'd5, 1'b0);
        send_entry(6'd1, 6'd0, 24'd9, 1'b0);
        send_entry(6'd1, 6'd2, 24'd7, 1'b0);
        send_entry(6'd2, 6'd1, 24'd2, 1'b0);
        send_entry(6'd2, 6'd0, 24'd3, 1'b1);

        write_town_count(7'd1);
        send_entry(6'd63, 6'd63, '0, 1'b1);

        // full matrix at the largest distance: every step but the last is a tie
        write_town_count(CNT_W'(FULL_TOWNS));
        for (int a = 0; a < FULL_TOWNS; a++)
            for (int b = 0; b < FULL_TOWNS; b++)
                if (a != b)
                    send_entry(TOWN_W'(a), TOWN_W'(b), FAR_AWAY,
                               (a == FULL_TOWNS - 1 && b == FULL_TOWNS - 2));

        write_town_count(7'd2);
        send_entry(6'd1, 6'd0, 24'd0, 1'b1);

        // random tours: mostly entries inside the active towns, some anywhere
        tour_no = 0;
        random_entries = 0;
        while (random_entries < RANDOM_ENTRIES) begin
            if (tour_no % 3 == 0)
                write_town_count(pick_town_count());
            else if ($urandom_range(0, 5) == 0)
                await_idle();
            steady = (tour_no >= 6 && tour_no < 11);
            n = tracker.tour_size();
            count = $urandom_range(0, 10);
            repeat (count) begin
                if ($urandom_range(0, 4) == 0)
                    send_entry(TOWN_W'($urandom_range(0, 63)), TOWN_W'($urandom_range(0, 63)),
                               pick_distance(), 1'b0);
                else
                    send_entry(TOWN_W'($urandom_range(0, n - 1)),
                               TOWN_W'($urandom_range(0, n - 1)), pick_distance(), 1'b0);
            end
            if ($urandom_range(0, 3) == 0)
                send_entry(TOWN_W'($urandom_range(0, 63)), TOWN_W'($urandom_range(0, 63)),
                           pick_distance(), 1'b1);
            else
                send_entry(TOWN_W'($urandom_range(0, n - 1)), TOWN_W'($urandom_range(0, n - 1)),
                           pick_distance(), 1'b1);
            random_entries += count + 1;
            tour_no++;
        end
        steady = 1'b0;

        await_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.planned_stops.size() != 0) begin
            $display("%0t: %0d tour stops never arrived", $time, tracker.planned_stops.size());
            tracker.errors++;
        end

        $display("sent %0d matrix entries, planned %0d tours, checked %0d tour stops",
                 entries_sent, tracker.tours_planned, tracker.stops_checked);
        $display("tours of 2 to %0d towns incl. clamped counts, ties, zero and full-scale edges",
                 FULL_TOWNS);
        if (tracker.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
